/* rtl/core/tbls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_pkg: shared types and constants for the tiled line stepper
// Opcodes, tile geometry and the decoded direction set passed between the
// top level and the position update logic.
// ----------------------------------------------------------------------------
package tbls_pkg;

    // Opcode of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Tile geometry: 8 bytes per tile, 256 bytes per tile row
    localparam logic [15:0] TILE_STEP     = 16'd8;
    localparam logic [15:0] TILE_ROW_SKIP = 16'd256 - 16'd8;
    localparam logic [7:0]  LEFT_BIT      = 8'd128;
    localparam logic [7:0]  RIGHT_BIT     = 8'd1;
    localparam logic [2:0]  ROW_BITS      = 3'd7;

    // Direction of one axis, taken from the sign of a two-bit move
    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_POS  = 2'd1,
        MOVE_NEG  = 2'd2
    } t_move_kind;

    // Horizontal and vertical direction applied in one step
    typedef struct packed {
        t_move_kind x;
        t_move_kind y;
    } t_move_set;

    // Decode a two-bit signed move: zero none, top bit set negative
    function automatic t_move_kind move_kind(input logic [1:0] bits);
        t_move_kind kind;
        if (bits == 2'b00) begin
            kind = MOVE_NONE;
        end else if (bits[1]) begin
            kind = MOVE_NEG;
        end else begin
            kind = MOVE_POS;
        end
        return kind;
    endfunction

endpackage

/* rtl/core/tbls_move.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_move: pixel position update
// Moves the bit mask and byte address by one pixel horizontally and then
// vertically, wrapping across tile and tile-row boundaries.
// ----------------------------------------------------------------------------
module tbls_move (
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_mask,
    input  tbls_pkg::t_move_set i_move,
    output logic [15:0]        o_address,
    output logic [7:0]         o_mask
);

    logic [15:0] x_address;
    logic [7:0]  shifted;
    logic [15:0] y_address;

    // Horizontal: shift the mask, cross into the neighbouring tile on empty
    always_comb begin
        x_address = i_address;
        o_mask    = i_mask;
        shifted   = i_mask;
        unique case (i_move.x)
            tbls_pkg::MOVE_POS: begin
                shifted = i_mask >> 1;
                if (shifted == 8'd0) begin
                    x_address = i_address + tbls_pkg::TILE_STEP;
                    o_mask    = tbls_pkg::LEFT_BIT;
                end else begin
                    o_mask = shifted;
                end
            end
            tbls_pkg::MOVE_NEG: begin
                shifted = i_mask << 1;
                if (shifted == 8'd0) begin
                    x_address = i_address - tbls_pkg::TILE_STEP;
                    o_mask    = tbls_pkg::RIGHT_BIT;
                end else begin
                    o_mask = shifted;
                end
            end
            default: begin
                o_mask = i_mask;
            end
        endcase
    end

    // Vertical: step one byte row, skip to the adjacent tile row on wrap
    always_comb begin
        y_address = x_address;
        o_address = x_address;
        unique case (i_move.y)
            tbls_pkg::MOVE_POS: begin
                y_address = x_address + 16'd1;
                if (y_address[2:0] == 3'd0) begin
                    o_address = y_address + tbls_pkg::TILE_ROW_SKIP;
                end else begin
                    o_address = y_address;
                end
            end
            tbls_pkg::MOVE_NEG: begin
                y_address = x_address - 16'd1;
                if (y_address[2:0] == tbls_pkg::ROW_BITS) begin
                    o_address = y_address - tbls_pkg::TILE_ROW_SKIP;
                end else begin
                    o_address = y_address;
                end
            end
            default: begin
                o_address = x_address;
            end
        endcase
    end

endmodule

/* rtl/core/tiled_bresenham_line_stepper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_bresenham_line_stepper_unit: pixel stepper for a prepared line
// Loads a line set up outside and emits one byte address and OR mask per
// step word on a bitmap of 8x8 tiles.
// ----------------------------------------------------------------------------
// One input word is taken every clock and its pixel, if any, appears in the
// output register on the next clock, so a line of N pixels streams out at one
// pixel per cycle. The pace is set by the single path from the line state
// through the decision add and the tile wrap logic into the state and result
// registers. Input is stalled only while a result is held and the output side
// is stalling. A load word gives no result and replaces any line in progress;
// a step word with no active line is dropped.
module tiled_bresenham_line_stepper_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [15:0]        i_start_address,
    input  logic [7:0]         i_start_mask,
    input  logic [15:0]        i_pixel_count,
    input  logic signed [15:0] i_error_start,
    input  logic signed [15:0] i_inc_when_negative,
    input  logic signed [15:0] i_inc_when_nonnegative,
    input  logic signed [1:0]  i_x_move_negative,
    input  logic signed [1:0]  i_y_move_negative,
    input  logic signed [1:0]  i_x_move_nonnegative,
    input  logic signed [1:0]  i_y_move_nonnegative,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_write_address,
    output logic [7:0]         o_or_mask,
    output logic               o_last_pixel
);

    // Line state
    logic [15:0] r_cur_address;
    logic [7:0]  r_cur_mask;
    logic [15:0] r_decision;
    logic [15:0] r_pixels_left;
    logic [15:0] r_step_neg;
    logic [15:0] r_step_nonneg;
    logic [7:0]  r_moves;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_address;
    logic [7:0]  r_out_mask;
    logic        r_out_last;

    logic                accept;
    logic                emit;
    logic                negative;
    tbls_pkg::t_move_set move_sel;
    logic [15:0]         n_address;
    logic [7:0]          n_mask;
    logic [15:0]         n_decision;

    // Hold input only while a result waits on a stalled output
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign emit    = accept & (i_opcode == tbls_pkg::OP_STEP) & (r_pixels_left != 16'd0);

    // Pick the increment and direction pair by the decision sign
    assign negative = r_decision[15];
    always_comb begin
        if (negative) begin
            n_decision = r_decision + r_step_neg;
            move_sel.x = tbls_pkg::move_kind(r_moves[1:0]);
            move_sel.y = tbls_pkg::move_kind(r_moves[3:2]);
        end else begin
            n_decision = r_decision + r_step_nonneg;
            move_sel.x = tbls_pkg::move_kind(r_moves[5:4]);
            move_sel.y = tbls_pkg::move_kind(r_moves[7:6]);
        end
    end

    tbls_move u_move (
        .i_address (r_cur_address),
        .i_mask    (r_cur_mask),
        .i_move    (move_sel),
        .o_address (n_address),
        .o_mask    (n_mask)
    );

    // Load a new line or advance the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_address <= 16'd0;
            r_cur_mask    <= tbls_pkg::LEFT_BIT;
            r_decision    <= 16'd0;
            r_pixels_left <= 16'd0;
            r_step_neg    <= 16'd0;
            r_step_nonneg <= 16'd0;
            r_moves       <= 8'd0;
        end else if (accept && i_opcode == tbls_pkg::OP_LOAD) begin
            r_cur_address <= i_start_address;
            r_cur_mask    <= (i_start_mask == 8'd0) ? tbls_pkg::LEFT_BIT : i_start_mask;
            r_pixels_left <= i_pixel_count;
            r_decision    <= i_error_start;
            r_step_neg    <= i_inc_when_negative;
            r_step_nonneg <= i_inc_when_nonnegative;
            r_moves       <= {i_y_move_nonnegative, i_x_move_nonnegative,
                              i_y_move_negative, i_x_move_negative};
        end else if (emit) begin
            r_cur_address <= n_address;
            r_cur_mask    <= n_mask;
            r_decision    <= n_decision;
            r_pixels_left <= r_pixels_left - 16'd1;
        end
    end

    // Result valid: set on an emitted pixel, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_address <= r_cur_address;
            r_out_mask    <= r_cur_mask;
            r_out_last    <= (r_pixels_left == 16'd1);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_address = r_out_address;
    assign o_or_mask       = r_out_mask;
    assign o_last_pixel    = r_out_last;

endmodule

/* dv/tb_tiled_bresenham_line_stepper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiled_bresenham_line_stepper_unit: self-checking bench for the line stepper
// Drives load and step words through the valid/stall input channel. A tracker
// class keeps its own copy of the line state and predicts each pixel write.
// Every result word taken from the output channel is compared field by field
// with the oldest predicted pixel. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_tiled_bresenham_line_stepper_unit;

    localparam int CYCLE_LIMIT  = 400000;

    // One input word as presented on the ports
    typedef struct {
        logic               opcode;
        logic [15:0]        start_address;
        logic [7:0]         start_mask;
        logic [15:0]        pixel_count;
        logic signed [15:0] error_start;
        logic signed [15:0] inc_neg;
        logic signed [15:0] inc_nonneg;
        logic signed [1:0]  x_neg;
        logic signed [1:0]  y_neg;
        logic signed [1:0]  x_nonneg;
        logic signed [1:0]  y_nonneg;
    } t_line_word;

    // One predicted pixel write
    typedef struct {
        logic [15:0] address;
        logic [7:0]  mask;
        logic        last;
    } t_pixel_write;

    // Line state tracker and pixel checker
    class line_pixel_tracker;
        logic [15:0]         cur_address;
        logic [7:0]          cur_mask;
        logic [15:0]         decision;
        logic [15:0]         pixels_left;
        logic [15:0]         step_neg;
        logic [15:0]         step_nonneg;
        tbls_pkg::t_move_set dir_neg;
        tbls_pkg::t_move_set dir_nonneg;
        t_pixel_write        pending_pixels[$];
        int                  errors;

        function new();
            cur_address = '0;
            cur_mask    = tbls_pkg::LEFT_BIT;
            decision    = '0;
            pixels_left = '0;
            step_neg    = '0;
            step_nonneg = '0;
            dir_neg     = '{tbls_pkg::MOVE_NONE, tbls_pkg::MOVE_NONE};
            dir_nonneg  = '{tbls_pkg::MOVE_NONE, tbls_pkg::MOVE_NONE};
            errors      = 0;
        endfunction

        // Only the sign of a move counts
        function tbls_pkg::t_move_kind direction_of(logic [1:0] bits);
            if (bits == 2'b00) begin
                return tbls_pkg::MOVE_NONE;
            end
            return bits[1] ? tbls_pkg::MOVE_NEG : tbls_pkg::MOVE_POS;
        endfunction

        // Shift the bit across the byte, wrapping into the neighbouring tile
        function void shift_across(tbls_pkg::t_move_kind kind);
            if (kind == tbls_pkg::MOVE_POS) begin
                cur_mask = cur_mask >> 1;
                if (cur_mask == 8'd0) begin
                    cur_address = cur_address + tbls_pkg::TILE_STEP;
                    cur_mask    = tbls_pkg::LEFT_BIT;
                end
            end else if (kind == tbls_pkg::MOVE_NEG) begin
                cur_mask = {cur_mask[6:0], 1'b0};
                if (cur_mask == 8'd0) begin
                    cur_address = cur_address - tbls_pkg::TILE_STEP;
                    cur_mask    = tbls_pkg::RIGHT_BIT;
                end
            end
        endfunction

        // Move one pixel row, skipping to the adjacent tile row at the tile edge
        function void shift_row(tbls_pkg::t_move_kind kind);
            if (kind == tbls_pkg::MOVE_POS) begin
                cur_address = cur_address + 16'd1;
                if (cur_address[2:0] == 3'd0) begin
                    cur_address = cur_address + tbls_pkg::TILE_ROW_SKIP;
                end
            end else if (kind == tbls_pkg::MOVE_NEG) begin
                cur_address = cur_address - 16'd1;
                if (cur_address[2:0] == tbls_pkg::ROW_BITS) begin
                    cur_address = cur_address - tbls_pkg::TILE_ROW_SKIP;
                end
            end
        endfunction

        // Note an accepted input word and queue the pixel it causes
        function void take_word(t_line_word w);
            t_pixel_write px;
            if (w.opcode == tbls_pkg::OP_LOAD) begin
                cur_address  = w.start_address;
                cur_mask     = (w.start_mask == 8'd0) ? tbls_pkg::LEFT_BIT : w.start_mask;
                pixels_left  = w.pixel_count;
                decision     = w.error_start;
                step_neg     = w.inc_neg;
                step_nonneg  = w.inc_nonneg;
                dir_neg.x    = direction_of(w.x_neg);
                dir_neg.y    = direction_of(w.y_neg);
                dir_nonneg.x = direction_of(w.x_nonneg);
                dir_nonneg.y = direction_of(w.y_nonneg);
                return;
            end
            if (pixels_left == 16'd0) begin
                return;
            end
            px.address = cur_address;
            px.mask    = cur_mask;
            px.last    = (pixels_left == 16'd1);
            pending_pixels.push_back(px);
            pixels_left = pixels_left - 16'd1;
            if (decision[15]) begin
                decision = decision + step_neg;
                shift_across(dir_neg.x);
                shift_row(dir_neg.y);
            end else begin
                decision = decision + step_nonneg;
                shift_across(dir_nonneg.x);
                shift_row(dir_nonneg.y);
            end
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        endfunction

        // Compare a result word with the oldest queued pixel
        function void check_pixel(logic [15:0] address, logic [7:0] mask, logic last);
            t_pixel_write px;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected word expected none actual %h/%h/%b",
                         $time, address, mask, last);
                return;
            end
            px = pending_pixels.pop_front();
            if (address !== px.address) report("write_address", px.address, address);
            if (mask !== px.mask) report("or_mask", {8'd0, px.mask}, {8'd0, mask});
            if (last !== px.last) report("last_pixel", {15'd0, px.last}, {15'd0, last});
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = tbls_pkg::OP_STEP;
    logic [15:0]        i_start_address = '0;
    logic [7:0]         i_start_mask = '0;
    logic [15:0]        i_pixel_count = '0;
    logic signed [15:0] i_error_start = '0;
    logic signed [15:0] i_inc_when_negative = '0;
    logic signed [15:0] i_inc_when_nonnegative = '0;
    logic signed [1:0]  i_x_move_negative = '0;
    logic signed [1:0]  i_y_move_negative = '0;
    logic signed [1:0]  i_x_move_nonnegative = '0;
    logic signed [1:0]  i_y_move_nonnegative = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [15:0]        o_write_address;
    logic [7:0]         o_or_mask;
    logic               o_last_pixel;

    line_pixel_tracker tracker = new();
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                cycle_count = 0;

    tiled_bresenham_line_stepper_unit u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_opcode               (i_opcode),
        .i_start_address        (i_start_address),
        .i_start_mask           (i_start_mask),
        .i_pixel_count          (i_pixel_count),
        .i_error_start          (i_error_start),
        .i_inc_when_negative    (i_inc_when_negative),
        .i_inc_when_nonnegative (i_inc_when_nonnegative),
        .i_x_move_negative      (i_x_move_negative),
        .i_y_move_negative      (i_y_move_negative),
        .i_x_move_nonnegative   (i_x_move_nonnegative),
        .i_y_move_nonnegative   (i_y_move_nonnegative),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_write_address        (o_write_address),
        .o_or_mask              (o_or_mask),
        .o_last_pixel           (o_last_pixel)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stall the output channel at random
    always @(negedge i_clk) begin
        i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_pixel(o_write_address, o_or_mask, o_last_pixel);
        end
    end

    // Present one word, hold it until taken, then note it; returns at a falling edge
    task automatic send_word(input t_line_word w);
        while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid                <= 1'b1;
        i_opcode               <= w.opcode;
        i_start_address        <= w.start_address;
        i_start_mask           <= w.start_mask;
        i_pixel_count          <= w.pixel_count;
        i_error_start          <= w.error_start;
        i_inc_when_negative    <= w.inc_neg;
        i_inc_when_nonnegative <= w.inc_nonneg;
        i_x_move_negative      <= w.x_neg;
        i_y_move_negative      <= w.y_neg;
        i_x_move_nonnegative   <= w.x_nonneg;
        i_y_move_nonnegative   <= w.y_nonneg;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        tracker.take_word(w);
        @(negedge i_clk);
    endtask

    function automatic t_line_word load_word(logic [15:0] address, logic [7:0] mask,
                                             logic [15:0] count, logic [15:0] err,
                                             logic [15:0] inc_n, logic [15:0] inc_p,
                                             logic [7:0] dirs);
        t_line_word w;
        w.opcode        = tbls_pkg::OP_LOAD;
        w.start_address = address;
        w.start_mask    = mask;
        w.pixel_count   = count;
        w.error_start   = err;
        w.inc_neg       = inc_n;
        w.inc_nonneg    = inc_p;
        w.x_neg         = dirs[1:0];
        w.y_neg         = dirs[3:2];
        w.x_nonneg      = dirs[5:4];
        w.y_nonneg      = dirs[7:6];
        return w;
    endfunction

    // Step word with random content in the unused fields
    function automatic t_line_word step_word();
        t_line_word w;
        w        = load_word(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 8'($urandom));
        w.opcode = tbls_pkg::OP_STEP;
        return w;
    endfunction

    function automatic t_line_word random_load();
        t_line_word w;
        int         pick;
        w    = step_word();
        w.opcode = tbls_pkg::OP_LOAD;
        // mostly one-hot masks, sometimes zero or several bits
        if ($urandom_range(99) < 80) begin
            w.start_mask = 8'd1 << $urandom_range(7);
        end
        pick = int'($urandom_range(99));
        if (pick < 65) begin
            w.pixel_count = 16'($urandom_range(1, 16));
        end else if (pick < 80) begin
            w.pixel_count = 16'($urandom_range(0, 2));
        end
        // half the lines get realistic increments
        if ($urandom_range(1) == 0) begin
            w.inc_neg     = 16'($urandom_range(0, 64));
            w.inc_nonneg  = -16'($urandom_range(0, 64));
            w.error_start = 16'($urandom_range(0, 128)) - 16'd64;
        end
        return w;
    endfunction

    task automatic random_lines(input int n_words);
        t_line_word w;
        int         sent;
        int         steps;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(99) < 5) begin
                // stray step, mostly onto an idle unit
                send_word(step_word());
                sent += 1;
            end else begin
                w = random_load();
                send_word(w);
                steps = (w.pixel_count > 24) ? int'($urandom_range(1, 24))
                                             : int'(w.pixel_count);
                // cut some lines short so the next load replaces them
                if ($urandom_range(3) == 0) begin
                    steps = int'($urandom_range(0, steps));
                end
                repeat (steps) send_word(step_word());
                sent += steps + 1;
                if ($urandom_range(4) == 0) begin
                    send_word(step_word());
                    sent += 1;
                end
            end
        end
    endtask

    initial begin
        // hold reset at the start
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 19;
        recv_idle_pct = 75;

        // step with no line loaded
        send_word(step_word());
        // zero mask, top address, decision at its minimum, nonnegative x move as -2
        send_word(load_word(16'hFFFF, 8'h00, 16'd3, 16'h8000, 16'h7FFF, 16'h8000,
                            8'b11_10_01_01));
        repeat (4) send_word(step_word());
        // bottom address and rightmost bit, moving right and down, then left and up to wrap below zero
        send_word(load_word(16'h0000, 8'h01, 16'd4, 16'h0000, 16'hFFFF, 16'hFFFF,
                            8'b01_01_11_11));
        repeat (4) send_word(step_word());
        // several bits in the mask, full count, cut short by the next load
        send_word(load_word(16'h00F7, 8'hA5, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h8001,
                            8'b11_01_01_11));
        repeat (3) send_word(step_word());
        // zero pixel count leaves the unit idle
        send_word(load_word(16'h5A5A, 8'h80, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                            8'b00_00_00_00));
        send_word(step_word());
        send_word(load_word(16'h0007, 8'h80, 16'd2, 16'hFFFF, 16'h0000, 16'h0000,
                            8'b00_00_10_00));
        repeat (2) send_word(step_word());

        random_lines(600);
        send_idle_pct = 75;
        recv_idle_pct = 19;
        random_lines(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_lines(600);
        i_valid <= 1'b0;

        // drain the output channel, then allow for the pipeline
        while (tracker.pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
